[sv/slex_pkg.sv]
// shared types, widths and result kinds for the s-expression byte lexer
package slex_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int MAX_RES         = 3;
    localparam int CHAR_W          = 8;
    localparam int KIND_W          = 3;
    localparam int VAL_W           = 64;
    localparam int OUT_DATA_W      = CHAR_W + VAL_W;

    // result kinds
    localparam logic [KIND_W-1:0] K_TEXT    = 3'd0;
    localparam logic [KIND_W-1:0] K_SYM_END = 3'd1;
    localparam logic [KIND_W-1:0] K_INT_END = 3'd2;
    localparam logic [KIND_W-1:0] K_STR_END = 3'd3;
    localparam logic [KIND_W-1:0] K_LPAREN  = 3'd4;
    localparam logic [KIND_W-1:0] K_RPAREN  = 3'd5;
    localparam logic [KIND_W-1:0] K_UNTERM  = 3'd6;
    localparam logic [KIND_W-1:0] K_DEC_END = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] ch;
    } t_op;

    // one queue entry: all results caused by one input byte
    typedef struct packed {
        logic [1:0]              cnt;
        t_op [MAX_RES-1:0]       ops;
        logic [VAL_W-1:0]        value;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

[sv/slex_front.sv]
// front end: byte classification, lexer state and result generation
module slex_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_byte,
    input  logic            i_end,
    input  slex_pkg::t_qstat i_qstat,
    output logic            o_push,
    output slex_pkg::t_entry o_entry
);
    import slex_pkg::*;

    localparam logic [2:0] M_IDLE  = 3'd0;
    localparam logic [2:0] M_STR   = 3'd1;
    localparam logic [2:0] M_SYM   = 3'd2;
    localparam logic [2:0] M_SLASH = 3'd3;
    localparam logic [2:0] M_LINE  = 3'd4;
    localparam logic [2:0] M_BLOCK = 3'd5;
    localparam logic [2:0] M_STAR  = 3'd6;

    localparam logic [2:0] C_OTHER = 3'd0;
    localparam logic [2:0] C_SPACE = 3'd1;
    localparam logic [2:0] C_QUOTE = 3'd2;
    localparam logic [2:0] C_LP    = 3'd3;
    localparam logic [2:0] C_RP    = 3'd4;

    localparam logic [7:0] CH_LP     = 8'h28;
    localparam logic [7:0] CH_RP     = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [VAL_W-1:0] POS_LIMIT = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] NEG_LIMIT = {1'b1, {(VAL_W-1){1'b0}}};

    function automatic logic [2:0] classify(input logic [7:0] c);
        logic [2:0] r;
        r = C_OTHER;
        if (c == CH_LP) begin
            r = C_LP;
        end else if (c == CH_RP) begin
            r = C_RP;
        end else if (c == CH_QUOTE) begin
            r = C_QUOTE;
        end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            r = C_SPACE;
        end
        return r;
    endfunction

    logic [2:0]       r_mode, n_mode;
    logic             r_esc, n_esc;
    logic [VAL_W-1:0] r_acc, n_acc;
    logic             r_intp, n_intp;
    logic             r_neg, n_neg;
    logic             r_digit, n_digit;
    logic             r_dot, n_dot;
    logic             r_numst, n_numst;

    // state seen by the active-byte path (after an implied '/' symbol start)
    logic [2:0]       a_mode;
    logic             a_esc, a_intp, a_neg, a_digit, a_dot, a_numst;
    logic [VAL_W-1:0] a_acc;

    logic             do_active, go_idle, is_digit, escaped;
    logic [2:0]       cls;
    logic [3:0]       dval;
    logic [VAL_W+3:0] prod;
    logic [VAL_W-1:0] limit;
    logic [KIND_W-1:0] end_kind;
    logic [VAL_W-1:0] end_val;
    logic [1:0]       cnt;
    t_op [MAX_RES-1:0] ops;
    logic [VAL_W-1:0] val;
    logic             accept;

    assign o_ready = !i_qstat.full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_mode  = r_mode;
        n_esc   = r_esc;
        n_acc   = r_acc;
        n_intp  = r_intp;
        n_neg   = r_neg;
        n_digit = r_digit;
        n_dot   = r_dot;
        n_numst = r_numst;

        a_mode  = (r_mode == M_STR || r_mode == M_SYM) ? r_mode : M_IDLE;
        a_esc   = r_esc;
        a_acc   = r_acc;
        a_intp  = r_intp;
        a_neg   = r_neg;
        a_digit = r_digit;
        a_dot   = r_dot;
        a_numst = r_numst;

        do_active = 1'b0;
        go_idle   = 1'b0;
        escaped   = 1'b0;
        cls       = C_OTHER;
        cnt       = 2'd0;
        ops       = '0;
        val       = '0;

        is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
        dval     = i_byte[3:0];

        if (i_end) begin
            unique case (r_mode)
                M_STR: begin
                    ops[cnt] = '{kind: K_UNTERM, ch: '0};
                    cnt = cnt + 2'd1;
                end
                M_SYM: begin
                    // end kind and value come from the registered number state
                    ops[cnt] = '{kind: ((r_intp && r_digit) ? K_INT_END :
                                        (r_dot && r_numst) ? K_DEC_END : K_SYM_END),
                                 ch: '0};
                    cnt = cnt + 2'd1;
                    if (r_intp && r_digit) begin
                        val = r_neg ? (VAL_W'(0) - r_acc) : r_acc;
                    end
                end
                M_SLASH: begin
                    ops[cnt] = '{kind: K_TEXT, ch: CH_SLASH};
                    cnt = cnt + 2'd1;
                    ops[cnt] = '{kind: K_SYM_END, ch: '0};
                    cnt = cnt + 2'd1;
                end
                default: begin
                end
            endcase
            n_mode  = M_IDLE;
            n_esc   = 1'b0;
            n_acc   = '0;
            n_intp  = 1'b0;
            n_neg   = 1'b0;
            n_digit = 1'b0;
            n_dot   = 1'b0;
            n_numst = 1'b0;
        end else begin
            unique case (r_mode)
                M_LINE: begin
                    if (i_byte == CH_LF || i_byte == CH_CR) begin
                        n_mode = M_IDLE;
                    end
                end
                M_BLOCK: begin
                    if (i_byte == CH_STAR) begin
                        n_mode = M_STAR;
                    end
                end
                M_STAR: begin
                    if (i_byte == CH_SLASH) begin
                        n_mode = M_IDLE;
                    end else if (i_byte != CH_STAR) begin
                        n_mode = M_BLOCK;
                    end
                end
                M_SLASH: begin
                    if (i_byte == CH_STAR) begin
                        n_mode = M_BLOCK;
                    end else if (i_byte == CH_SLASH) begin
                        n_mode = M_LINE;
                    end else begin
                        // lone slash becomes a symbol byte; this byte is then handled in symbol mode
                        ops[cnt] = '{kind: K_TEXT, ch: CH_SLASH};
                        cnt = cnt + 2'd1;
                        a_mode  = M_SYM;
                        a_esc   = 1'b0;
                        a_acc   = '0;
                        a_intp  = 1'b0;
                        a_neg   = 1'b0;
                        a_digit = 1'b0;
                        a_dot   = 1'b0;
                        a_numst = 1'b0;
                        do_active = 1'b1;
                    end
                end
                default: begin
                    do_active = 1'b1;
                end
            endcase
        end

        end_kind = (a_intp && a_digit) ? K_INT_END :
                   (a_dot && a_numst) ? K_DEC_END : K_SYM_END;
        end_val  = a_neg ? (VAL_W'(0) - a_acc) : a_acc;
        limit    = a_neg ? NEG_LIMIT : POS_LIMIT;
        // acc * 10 + digit, as shift-and-add
        prod     = ({4'b0, a_acc} << 3) + ({4'b0, a_acc} << 1) + {{VAL_W{1'b0}}, dval};

        if (do_active) begin
            n_mode  = a_mode;
            n_esc   = a_esc;
            n_acc   = a_acc;
            n_intp  = a_intp;
            n_neg   = a_neg;
            n_digit = a_digit;
            n_dot   = a_dot;
            n_numst = a_numst;
            if (!a_esc && i_byte == CH_BSLASH) begin
                n_esc = 1'b1;
            end else begin
                escaped = a_esc;
                n_esc   = 1'b0;
                cls     = escaped ? C_OTHER : classify(i_byte);
                if (a_mode == M_STR) begin
                    if (cls == C_QUOTE) begin
                        ops[cnt] = '{kind: K_STR_END, ch: '0};
                        cnt = cnt + 2'd1;
                        n_mode = M_IDLE;
                    end else begin
                        ops[cnt] = '{kind: K_TEXT, ch: i_byte};
                        cnt = cnt + 2'd1;
                    end
                end else if (a_mode == M_SYM && cls == C_OTHER) begin
                    ops[cnt] = '{kind: K_TEXT, ch: i_byte};
                    cnt = cnt + 2'd1;
                    if (i_byte == CH_DOT) begin
                        n_dot = 1'b1;
                    end
                    if (is_digit) begin
                        n_digit = 1'b1;
                        if (a_intp) begin
                            if (prod > {4'b0, limit}) begin
                                n_intp = 1'b0;
                            end else begin
                                n_acc = prod[VAL_W-1:0];
                            end
                        end
                    end else begin
                        n_intp = 1'b0;
                    end
                end else begin
                    if (a_mode == M_SYM) begin
                        ops[cnt] = '{kind: end_kind, ch: '0};
                        cnt = cnt + 2'd1;
                        if (end_kind == K_INT_END) begin
                            val = end_val;
                        end
                        n_mode  = M_IDLE;
                        n_acc   = '0;
                        n_intp  = 1'b0;
                        n_neg   = 1'b0;
                        n_digit = 1'b0;
                        n_dot   = 1'b0;
                        n_numst = 1'b0;
                        go_idle = (cls != C_SPACE);
                    end else begin
                        go_idle = 1'b1;
                    end
                end
            end
        end

        if (go_idle) begin
            n_mode = M_IDLE;
            unique case (cls)
                C_QUOTE: n_mode = M_STR;
                C_LP: begin
                    ops[cnt] = '{kind: K_LPAREN, ch: '0};
                    cnt = cnt + 2'd1;
                end
                C_RP: begin
                    ops[cnt] = '{kind: K_RPAREN, ch: '0};
                    cnt = cnt + 2'd1;
                end
                C_OTHER: begin
                    if (i_byte == CH_SLASH) begin
                        n_mode = M_SLASH;
                    end else begin
                        ops[cnt] = '{kind: K_TEXT, ch: i_byte};
                        cnt = cnt + 2'd1;
                        n_mode  = M_SYM;
                        n_numst = is_digit || i_byte == CH_DOT || i_byte == CH_MINUS;
                        n_neg   = (i_byte == CH_MINUS);
                        n_digit = is_digit;
                        n_dot   = (i_byte == CH_DOT);
                        n_intp  = is_digit || i_byte == CH_MINUS;
                        n_acc   = is_digit ? {{(VAL_W-4){1'b0}}, dval} : '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_push  = accept && (cnt != 2'd0);
    assign o_entry = '{cnt: cnt, ops: ops, value: val};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_esc   <= 1'b0;
            r_acc   <= '0;
            r_intp  <= 1'b0;
            r_neg   <= 1'b0;
            r_digit <= 1'b0;
            r_dot   <= 1'b0;
            r_numst <= 1'b0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_esc   <= n_esc;
            r_acc   <= n_acc;
            r_intp  <= n_intp;
            r_neg   <= n_neg;
            r_digit <= n_digit;
            r_dot   <= n_dot;
            r_numst <= n_numst;
        end
    end

endmodule

[sv/slex_queue.sv]
// short entry queue between the lexer front end and the result serializer
module slex_queue #(
    parameter int DEPTH = slex_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  slex_pkg::t_entry i_entry,
    input  logic             i_pop,
    output slex_pkg::t_entry o_head,
    output slex_pkg::t_qstat o_qstat
);
    import slex_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_head        = r_mem[r_rd];
    assign o_qstat.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_qstat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[sv/slex_back.sv]
// back end: serializes queued results into the output register
module slex_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  slex_pkg::t_entry            i_head,
    input  slex_pkg::t_qstat            i_qstat,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [slex_pkg::KIND_W-1:0] o_kind,
    output logic [slex_pkg::CHAR_W-1:0] o_char,
    output logic [slex_pkg::VAL_W-1:0]  o_value,
    output logic                        o_last
);
    import slex_pkg::*;

    logic              r_valid;
    logic [1:0]        r_idx;
    logic [KIND_W-1:0] r_kind;
    logic [CHAR_W-1:0] r_char;
    logic [VAL_W-1:0]  r_value;
    logic              r_last;
    logic              load, head_last;
    t_op               cur;

    assign load      = (!r_valid || i_ready) && !i_qstat.empty;
    assign cur       = i_head.ops[r_idx];
    assign head_last = (r_idx == i_head.cnt - 2'd1);
    assign o_pop     = load && head_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= head_last ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind  <= cur.kind;
            r_char  <= cur.ch;
            r_value <= (cur.kind == K_INT_END) ? i_head.value : '0;
            r_last  <= head_last;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_char  = r_char;
    assign o_value = r_value;
    assign o_last  = r_last;

endmodule

[sv/sexpr_byte_lexer_core.sv]
// top level of the s-expression byte lexer: front end, entry queue, result serializer
//
//  channel   dir  tdata                               tuser          tlast
//  s_axis    in   [7:0] text_byte                     [0] stream_end  -
//  m_axis    out  [7:0] char_out, [71:8] int_value    [2:0] kind      last result of a byte
//
//  the front end takes one byte per cycle whenever the entry queue has room
//  each byte gives zero to three results; the back end sends one result per cycle
//  while m_axis_tready is high, so the results of one byte leave one after another
//  the queue (QUEUE_DEPTH entries) absorbs bursts of multi-result bytes before
//  s_axis_tready drops; bytes with no result never enter the queue
//  reset is synchronous and active low
module sexpr_byte_lexer_core #(
    parameter int QUEUE_DEPTH = slex_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,   // text_byte
    input  logic [0:0]                       s_axis_tuser,   // stream_end
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [slex_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // char_out, int_value
    output logic [slex_pkg::KIND_W-1:0]      m_axis_tuser,   // kind
    output logic                             m_axis_tlast    // last
);
    import slex_pkg::*;

    t_entry            front_entry, q_head;
    t_qstat            q_stat;
    logic              q_push, q_pop;
    logic [CHAR_W-1:0] out_char;
    logic [VAL_W-1:0]  out_value;

    // front: classifies each byte, advances lexer state, builds one queue entry
    slex_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_end   (s_axis_tuser[0]),
        .i_qstat (q_stat),
        .o_push  (q_push),
        .o_entry (front_entry)
    );

    // decouples byte intake from result delivery
    slex_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (front_entry),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_qstat (q_stat)
    );

    // back: walks the results of the head entry into the output register
    slex_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .i_qstat (q_stat),
        .o_pop   (q_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_kind  (m_axis_tuser),
        .o_char  (out_char),
        .o_value (out_value),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {out_value, out_char};

`ifndef ASSERT_OFF
    // integer value only travels with an integer end
    a_value_only_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != K_INT_END |-> out_value == '0)
        else $error("int value set on a non-integer result");

    // a character only travels with a text byte transfer
    a_char_only_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != K_TEXT |-> out_char == '0)
        else $error("char set on a non-text result");

    // the front never writes into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("push into full queue");

    // the back never pops an empty queue
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");
`endif

endmodule

[dv/tb.sv]
// self-checking testbench for the s-expression byte lexer core
module tb;
    import slex_pkg::*;

    // character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LP    = 8'h28;
    localparam logic [7:0] CH_RP    = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_D0    = 8'h30;
    localparam logic [7:0] CH_D9    = 8'h39;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    // lexer modes
    localparam logic [2:0] LM_IDLE  = 3'd0;
    localparam logic [2:0] LM_STR   = 3'd1;
    localparam logic [2:0] LM_SYM   = 3'd2;
    localparam logic [2:0] LM_SLASH = 3'd3;
    localparam logic [2:0] LM_LINE  = 3'd4;
    localparam logic [2:0] LM_BLOCK = 3'd5;
    localparam logic [2:0] LM_STAR  = 3'd6;

    localparam int N_RAND     = 470;
    localparam int LONG_HOLD  = 200;
    localparam int WDOG_LIMIT = 3000;
    localparam int MAX_PRINT  = 60;

    typedef enum logic [2:0] {CC_OTHER, CC_SPACE, CC_QUOTE, CC_LP, CC_RP} t_cclass;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [7:0]        ch;
        logic [63:0]       val;
        logic              last;
    } t_tok;

    typedef struct packed {
        logic [7:0] b;
        logic       e;
        logic       hold;   // wait for all tokens to drain before offering
    } t_txin;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [7:0]                  s_axis_tdata = 8'h00;   // text_byte
    logic [0:0]                  s_axis_tuser = 1'b0;    // stream_end
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]       m_axis_tdata;           // char_out, int_value
    logic [KIND_W-1:0]           m_axis_tuser;           // kind
    logic                        m_axis_tlast;

    sexpr_byte_lexer_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_txin txin_q[$];
    t_tok  exp_tokens[$];
    t_tok  step_toks[$];
    int    err_cnt = 0;
    int    in_cnt = 0;
    int    quiet_cyc = 0;
    int    idle_cyc = 0;
    bit    hold_next = 1'b0;

    // lexer state mirror
    logic [2:0]  lx_mode = LM_IDLE;
    logic        lx_esc = 1'b0;
    logic [63:0] num_mag = 64'd0;
    logic        num_ok = 1'b0;
    logic        num_neg = 1'b0;
    logic        num_dig = 1'b0;
    logic        num_dot = 1'b0;
    logic        num_lead = 1'b0;

    task automatic report(input string msg);
        if (err_cnt < MAX_PRINT)
            $display("tb: mismatch at %0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    // ---------------- token predictor ----------------
    function automatic void put_tok(input logic [KIND_W-1:0] k, input logic [7:0] c,
                                    input logic [63:0] v);
        t_tok t;
        t.kind = k;
        t.ch   = c;
        t.val  = v;
        t.last = 1'b0;
        if (step_toks.size() < MAX_RES)
            step_toks.push_back(t);
    endfunction

    function automatic t_cclass char_class(input logic [7:0] c);
        if (c == CH_LP) return CC_LP;
        if (c == CH_RP) return CC_RP;
        if (c == CH_QUOTE) return CC_QUOTE;
        if (c == CH_SP || (c >= CH_TAB && c <= CH_CR)) return CC_SPACE;
        return CC_OTHER;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_D0 && c <= CH_D9;
    endfunction

    function automatic void clear_num();
        num_mag  = 64'd0;
        num_ok   = 1'b0;
        num_neg  = 1'b0;
        num_dig  = 1'b0;
        num_dot  = 1'b0;
        num_lead = 1'b0;
    endfunction

    function automatic void begin_sym(input logic [7:0] c);
        bit dg;
        dg = is_digit(c);
        put_tok(K_TEXT, c, 64'd0);
        lx_mode  = LM_SYM;
        num_lead = dg || c == CH_DOT || c == CH_MINUS;
        num_neg  = (c == CH_MINUS);
        num_dig  = dg;
        num_dot  = (c == CH_DOT);
        num_ok   = dg || c == CH_MINUS;
        num_mag  = dg ? {56'd0, c - CH_D0} : 64'd0;
    endfunction

    function automatic void sym_byte(input logic [7:0] c);
        logic [63:0] d;
        logic [63:0] lim;
        put_tok(K_TEXT, c, 64'd0);
        if (c == CH_DOT)
            num_dot = 1'b1;
        if (is_digit(c)) begin
            d   = {56'd0, c - CH_D0};
            lim = num_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            num_dig = 1'b1;
            if (num_ok) begin
                if (num_mag > (lim - d) / 64'd10)
                    num_ok = 1'b0;
                else
                    num_mag = num_mag * 64'd10 + d;
            end
        end else begin
            num_ok = 1'b0;
        end
    endfunction

    function automatic void close_sym();
        if (num_ok && num_dig)
            put_tok(K_INT_END, 8'h00, num_neg ? -num_mag : num_mag);
        else if (num_dot && num_lead)
            put_tok(K_DEC_END, 8'h00, 64'd0);
        else
            put_tok(K_SYM_END, 8'h00, 64'd0);
        lx_mode = LM_IDLE;
        clear_num();
    endfunction

    function automatic void idle_char(input logic [7:0] c, input t_cclass cls);
        lx_mode = LM_IDLE;
        if (cls == CC_QUOTE)
            lx_mode = LM_STR;
        else if (cls == CC_LP)
            put_tok(K_LPAREN, 8'h00, 64'd0);
        else if (cls == CC_RP)
            put_tok(K_RPAREN, 8'h00, 64'd0);
        else if (cls == CC_OTHER) begin
            if (c == CH_SLASH)
                lx_mode = LM_SLASH;
            else
                begin_sym(c);
        end
    endfunction

    function automatic void live_char(input logic [7:0] c);
        bit      was_esc;
        t_cclass cls;
        was_esc = lx_esc;
        if (was_esc) begin
            lx_esc = 1'b0;
        end else if (c == CH_BSL) begin
            lx_esc = 1'b1;
            return;
        end
        cls = was_esc ? CC_OTHER : char_class(c);
        if (lx_mode == LM_STR) begin
            if (cls == CC_QUOTE) begin
                put_tok(K_STR_END, 8'h00, 64'd0);
                lx_mode = LM_IDLE;
            end else begin
                put_tok(K_TEXT, c, 64'd0);
            end
        end else if (lx_mode == LM_SYM) begin
            if (cls == CC_SPACE) begin
                close_sym();
            end else if (cls == CC_OTHER) begin
                sym_byte(c);
            end else begin
                close_sym();
                idle_char(c, cls);
            end
        end else begin
            idle_char(c, cls);
        end
    endfunction

    // one accepted byte: append its tokens to the expected queue
    function automatic void lex_byte(input logic [7:0] c, input logic e);
        t_tok t;
        step_toks.delete();
        if (e) begin
            if (lx_mode == LM_STR) begin
                put_tok(K_UNTERM, 8'h00, 64'd0);
            end else if (lx_mode == LM_SYM) begin
                close_sym();
            end else if (lx_mode == LM_SLASH) begin
                begin_sym(CH_SLASH);
                close_sym();
            end
            lx_mode = LM_IDLE;
            lx_esc  = 1'b0;
            clear_num();
        end else begin
            case (lx_mode)
                LM_LINE: begin
                    if (c == CH_LF || c == CH_CR)
                        lx_mode = LM_IDLE;
                end
                LM_BLOCK: begin
                    if (c == CH_STAR)
                        lx_mode = LM_STAR;
                end
                LM_STAR: begin
                    if (c == CH_SLASH)
                        lx_mode = LM_IDLE;
                    else if (c != CH_STAR)
                        lx_mode = LM_BLOCK;
                end
                LM_SLASH: begin
                    if (c == CH_STAR) begin
                        lx_mode = LM_BLOCK;
                    end else if (c == CH_SLASH) begin
                        lx_mode = LM_LINE;
                    end else begin
                        begin_sym(CH_SLASH);
                        live_char(c);
                    end
                end
                LM_STR, LM_SYM: begin
                    live_char(c);
                end
                default: begin
                    lx_mode = LM_IDLE;
                    live_char(c);
                end
            endcase
        end
        for (int i = 0; i < step_toks.size(); i++) begin
            t = step_toks[i];
            t.last = (i == step_toks.size() - 1);
            exp_tokens.push_back(t);
        end
    endfunction

    // ---------------- stimulus builders ----------------
    function automatic void push_byte(input logic [7:0] b, input logic e);
        t_txin x;
        x.b    = b;
        x.e    = e;
        x.hold = hold_next;
        hold_next = 1'b0;
        txin_q.push_back(x);
    endfunction

    function automatic void push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], 1'b0);
    endfunction

    function automatic logic [7:0] ws_byte();
        case ($urandom_range(0, 5))
            0: return CH_TAB;
            1: return CH_LF;
            2: return CH_VT;
            3: return CH_FF;
            4: return CH_CR;
            default: return CH_SP;
        endcase
    endfunction

    function automatic void push_digits(input int n);
        for (int i = 0; i < n; i++)
            push_byte(CH_D0 + 8'($urandom_range(0, 9)), 1'b0);
    endfunction

    // one random token; returns the number of bytes pushed
    function automatic int add_token();
        int          sel;
        int          n0;
        int          len;
        logic [63:0] v;
        logic [7:0]  b;
        n0  = txin_q.size();
        sel = $urandom_range(0, 99);
        if (sel < 22) begin
            // integers, overflow edges included
            case ($urandom_range(0, 9))
                0: push_str("9223372036854775807");
                1: push_str("9223372036854775808");
                2: push_str("-9223372036854775808");
                3: push_str("-9223372036854775809");
                4: begin
                    v = {$urandom, $urandom};
                    if ($urandom_range(0, 1)) push_byte(CH_MINUS, 1'b0);
                    push_str($sformatf("%0d", v));
                end
                5: begin
                    push_str("000");
                    push_digits($urandom_range(1, 3));
                end
                6: push_byte(CH_MINUS, 1'b0);
                default: begin
                    if ($urandom_range(0, 1)) push_byte(CH_MINUS, 1'b0);
                    push_digits($urandom_range(1, 4));
                end
            endcase
        end else if (sel < 32) begin
            // decimal candidates and near misses
            case ($urandom_range(0, 3))
                0: push_byte(CH_MINUS, 1'b0);
                1: push_byte(8'h61 + 8'($urandom_range(0, 25)), 1'b0);
                default: ;
            endcase
            push_digits($urandom_range(0, 3));
            push_byte(CH_DOT, 1'b0);
            push_digits($urandom_range(0, 3));
            if ($urandom_range(0, 3) == 0) begin
                push_byte(CH_DOT, 1'b0);
                push_digits(1);
            end
        end else if (sel < 48) begin
            // plain symbols with escapes, high bytes and nulls
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: b = 8'h61 + 8'($urandom_range(0, 25));
                    5: b = 8'($urandom_range(128, 255));
                    6: b = CH_D0 + 8'($urandom_range(0, 9));
                    7: b = ($urandom_range(0, 1)) ? CH_MINUS : CH_DOT;
                    8: begin
                        push_byte(CH_BSL, 1'b0);
                        b = 8'($urandom_range(0, 255));
                    end
                    default: b = ($urandom_range(0, 1)) ? 8'h00 : CH_SLASH;
                endcase
                push_byte(b, 1'b0);
            end
        end else if (sel < 60) begin
            // quoted string with escapes
            push_byte(CH_QUOTE, 1'b0);
            len = $urandom_range(0, 8);
            for (int i = 0; i < len; i++) begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_QUOTE || b == CH_BSL || $urandom_range(0, 5) == 0) begin
                    push_byte(CH_BSL, 1'b0);
                    if ($urandom_range(0, 1)) b = CH_QUOTE;
                end
                push_byte(b, 1'b0);
            end
            push_byte(CH_QUOTE, 1'b0);
        end else if (sel < 75) begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
                push_byte(($urandom_range(0, 1)) ? CH_LP : CH_RP, 1'b0);
        end else if (sel < 82) begin
            // line or block comment
            push_byte(CH_SLASH, 1'b0);
            if ($urandom_range(0, 1)) begin
                push_byte(CH_SLASH, 1'b0);
                len = $urandom_range(0, 5);
                for (int i = 0; i < len; i++)
                    push_byte(8'h61 + 8'($urandom_range(0, 25)), 1'b0);
                push_byte(($urandom_range(0, 1)) ? CH_LF : CH_CR, 1'b0);
            end else begin
                push_byte(CH_STAR, 1'b0);
                len = $urandom_range(0, 6);
                for (int i = 0; i < len; i++) begin
                    case ($urandom_range(0, 3))
                        0: push_byte(CH_STAR, 1'b0);
                        1: push_byte(CH_SLASH, 1'b0);
                        default: push_byte(8'($urandom_range(0, 255)), 1'b0);
                    endcase
                end
                push_byte(CH_STAR, 1'b0);
                push_byte(CH_SLASH, 1'b0);
            end
        end else if (sel < 90) begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
                push_byte(8'($urandom_range(0, 255)), 1'b0);
        end else if (sel < 95) begin
            // stream close, often with a token still open
            case ($urandom_range(0, 3))
                0: push_str("\"ab");
                1: push_byte(CH_SLASH, 1'b0);
                2: push_str("-42");
                default: ;
            endcase
            push_byte(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
                push_byte(ws_byte(), 1'b0);
        end
        if ($urandom_range(0, 9) < 7)
            push_byte(ws_byte(), 1'b0);
        return txin_q.size() - n0;
    endfunction

    // ---------------- driver ----------------
    int burst_left = 8;
    int gap_left = 0;
    bit in_acc;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            in_acc = s_axis_tvalid && s_axis_tready;
            if (in_acc)
                void'(txin_q.pop_front());
            // a pending offer must stay put until it is taken
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (txin_q.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (txin_q[0].hold && (in_acc || quiet_cyc < 4)) begin
                    s_axis_tvalid <= 1'b0;
                end else if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= txin_q[0].b;
                    s_axis_tuser  <= txin_q[0].e;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // ---------------- receiver backpressure ----------------
    int          rx_cyc = 0;
    int          hold_cnt = 0;
    int          next_hold_at = 150;
    logic [15:0] rx_pat = 16'hFFFF;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            rx_cyc <= rx_cyc + 1;
            if (hold_cnt != 0) begin
                hold_cnt <= hold_cnt - 1;
                m_axis_tready <= 1'b0;
            end else if (in_cnt >= next_hold_at) begin
                // long hold-off so the entry queue fills and input stalls
                next_hold_at <= next_hold_at + 230;
                hold_cnt <= LONG_HOLD;
                m_axis_tready <= 1'b0;
            end else begin
                if (rx_cyc[5:0] == 6'd0) begin
                    case ($urandom_range(0, 3))
                        0: rx_pat = 16'hFFFF;
                        1: rx_pat = 16'($urandom);
                        2: rx_pat = 16'($urandom) & 16'($urandom);
                        default: rx_pat = 16'($urandom) | 16'($urandom);
                    endcase
                end
                m_axis_tready <= rx_pat[rx_cyc[3:0]];
            end
        end
    end

    // ---------------- monitor and checker ----------------
    t_tok got_exp;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                lex_byte(s_axis_tdata, s_axis_tuser[0]);
                in_cnt <= in_cnt + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (exp_tokens.size() == 0) begin
                    report($sformatf("unexpected token kind %0d", m_axis_tuser));
                end else begin
                    got_exp = exp_tokens.pop_front();
                    if (m_axis_tuser != got_exp.kind)
                        report($sformatf("kind %0d, want %0d", m_axis_tuser, got_exp.kind));
                    if (m_axis_tdata[7:0] != got_exp.ch)
                        report($sformatf("char %02h, want %02h", m_axis_tdata[7:0],
                                         got_exp.ch));
                    if (m_axis_tdata[71:8] != got_exp.val)
                        report($sformatf("value %0d, want %0d",
                                         $signed(m_axis_tdata[71:8]), $signed(got_exp.val)));
                    if (m_axis_tlast != got_exp.last)
                        report($sformatf("last %0b, want %0b", m_axis_tlast, got_exp.last));
                end
            end
            quiet_cyc <= (exp_tokens.size() == 0) ? quiet_cyc + 1 : 0;
        end
    end

    // watchdog: nothing moving on either side for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cyc <= 0;
            else
                idle_cyc <= idle_cyc + 1;
            if (idle_cyc >= WDOG_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // ---------------- stimulus and end of run ----------------
    int n_rand;

    initial begin
        // directed: parens, string with escaped quote, symbol cut by a quote
        push_str("(a\"x\\\"\")");
        // block comment: slash star slash does not close it
        push_str("/*/*/");
        // decimal cut by a paren, escaped paren outside a string
        push_str(".5)\\(");
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(CH_SP, 1'b0);
        // line comment, slash followed by a paren (three tokens)
        push_str("//x\n/)");
        // stream close inside a string, after a lone slash, inside an integer
        push_str("\"");
        push_byte(8'hA5, 1'b1);
        push_str("/");
        push_byte(8'h5A, 1'b1);
        push_str("-9");
        push_byte(8'h00, 1'b1);

        n_rand = txin_q.size();
        hold_next = 1'b1;
        while (n_rand < N_RAND) begin
            if (n_rand < 250 && n_rand + 12 >= 250)
                hold_next = 1'b1;
            n_rand += add_token();
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (txin_q.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        while (quiet_cyc < 16)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

[filelist.f]
sv/slex_pkg.sv
sv/slex_front.sv
sv/slex_queue.sv
sv/slex_back.sv
sv/sexpr_byte_lexer_core.sv
dv/tb.sv
